[src/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   // Request op codes
   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_CREATE      = 3'd1,
      OP_DELAY       = 3'd2,
      OP_LAUNCH      = 3'd3,
      OP_SWITCH_DONE = 3'd4
   } pts_op_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } pts_state_type;

   // Priority value that is never selected
   localparam logic [7:0] PRIO_NONE = 8'd255;

   // Per-slot update strobes from the controller
   typedef struct packed {
      logic create_en;
      logic delay_en;
      logic tick_en;
   } pts_ctrl_type;

endpackage

[src/pts_cell.sv]
// ----------------------------------------------------------------------------
// pts_cell
// One task slot: priority, ready flag and delay countdown, plus one stage of
// the selection chain that carries the best ready task toward the last slot.
// ----------------------------------------------------------------------------
module pts_cell #(
   parameter int IDX_W      = 3,
   parameter int SLOT_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pts_pkg::pts_ctrl_type ctrl,
   input  logic [7:0]           new_priority,
   input  logic [31:0]          new_delay,
   input  logic                 best_found_prev,
   input  logic [7:0]           best_prio_prev,
   input  logic [IDX_W-1:0]     best_idx_prev,
   output logic                 best_found,
   output logic [7:0]           best_prio,
   output logic [IDX_W-1:0]     best_idx
);
   import pts_pkg::*;

   logic              ready_ff,  ready_in;
   logic [7:0]        prio_ff,   prio_in;
   logic [31:0]       delay_ff,  delay_in;
   logic              bfound_ff, bfound_in;
   logic [7:0]        bprio_ff,  bprio_in;
   logic [IDX_W-1:0]  bidx_ff,   bidx_in;

   // Slot update: create, delay or one tick of countdown
   always_comb begin
      ready_in = ready_ff;
      prio_in  = prio_ff;
      delay_in = delay_ff;
      if (ctrl.create_en) begin
         prio_in  = new_priority;
         ready_in = 1'b1;
         delay_in = '0;
      end else if (ctrl.delay_en) begin
         ready_in = 1'b0;
         delay_in = new_delay;
      end else if (ctrl.tick_en && !ready_ff && (delay_ff != '0)) begin
         delay_in = delay_ff - 32'd1;
         if (delay_ff == 32'd1) begin
            ready_in = 1'b1;
         end
      end
   end

   // Chain stage: take this slot if it beats everything before it
   always_comb begin
      bfound_in = best_found_prev;
      bprio_in  = best_prio_prev;
      bidx_in   = best_idx_prev;
      if (ready_ff && (prio_ff < best_prio_prev)) begin
         bfound_in = 1'b1;
         bprio_in  = prio_ff;
         bidx_in   = IDX_W'(SLOT_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         prio_ff   <= PRIO_NONE;
         delay_ff  <= '0;
         bfound_ff <= 1'b0;
      end else begin
         ready_ff  <= ready_in;
         prio_ff   <= prio_in;
         delay_ff  <= delay_in;
         bfound_ff <= bfound_in;
      end
   end

   always_ff @(posedge clock) begin
      bprio_ff <= bprio_in;
      bidx_ff  <= bidx_in;
   end

   assign best_found = bfound_ff;
   assign best_prio  = bprio_ff;
   assign best_idx   = bidx_ff;

endmodule

[src/priority_task_scheduler_with_delays.sv]
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays
// Fixed-priority task scheduler built from a row of task-slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a rising edge with start high and busy low.
//   req_op selects tick, create, delay, launch or switch done; the other
//   req_ fields carry its arguments.
//   Every request gives exactly one response beat: rsp_valid is high for
//   one cycle with the status fields. The receiver cannot stall.
//   Create, delay, switch done and unused ops: the response comes in the
//   cycle after the request, and a new request may be taken in that cycle.
//   Tick and launch: slot state updates on the request edge, then the best
//   ready task ripples through the cell chain, one slot per cycle. busy
//   stays high while the scan counter steps through the whole chain, and
//   the response comes as busy drops, so a new request may be taken in the
//   response cycle; the chain length sets how long an item takes.
//   Reset (synchronous) empties the task table, clears the tick count and
//   drops the current and pending tasks.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_delays #(
   parameter int TASK_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_task_priority,
   input  logic [2:0]  req_task_index,
   input  logic [31:0] req_delay_count,
   output logic        rsp_valid,
   output logic        rsp_create_ok,
   output logic        rsp_switch_request,
   output logic [2:0]  rsp_pending_task,
   output logic        rsp_pending_valid,
   output logic [2:0]  rsp_running_task,
   output logic        rsp_running_valid,
   output logic [31:0] rsp_tick_total,
   output logic [3:0]  rsp_tasks_in_use
);
   import pts_pkg::*;

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   pts_state_type    state_ff,   state_in;
   pts_op_type       op_ff,      op_in;
   logic [CNT_W-1:0] scan_ff,    scan_in;
   logic [CNT_W-1:0] count_ff,   count_in;
   logic [31:0]      tick_ff,    tick_in;
   logic [IDX_W-1:0] cur_idx_ff, cur_idx_in;
   logic             cur_vld_ff, cur_vld_in;
   logic [IDX_W-1:0] nxt_idx_ff, nxt_idx_in;
   logic             nxt_vld_ff, nxt_vld_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   logic             rsp_create_ff, rsp_create_in;
   logic             rsp_switch_ff, rsp_switch_in;

   logic             accept;
   pts_op_type       req_op_code;
   logic             table_full;

   pts_ctrl_type     cell_ctrl   [TASK_SLOTS];
   logic             chain_found [TASK_SLOTS+1];
   logic [7:0]       chain_prio  [TASK_SLOTS+1];
   logic [IDX_W-1:0] chain_idx   [TASK_SLOTS+1];

   logic [IDX_W+2:0] pend_ext;
   logic [IDX_W+2:0] run_ext;
   logic [CNT_W+3:0] count_ext;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign req_op_code = pts_op_type'(req_op);
   assign table_full  = (count_ff == CNT_W'(TASK_SLOTS));

   // Head of the selection chain: nothing found yet
   assign chain_found[0] = 1'b0;
   assign chain_prio[0]  = PRIO_NONE;
   assign chain_idx[0]   = '0;

   // Row of task-slot cells
   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      assign cell_ctrl[i].create_en = accept && (req_op_code == OP_CREATE) &&
                                      (count_ff == CNT_W'(i));
      assign cell_ctrl[i].delay_en  = accept && (req_op_code == OP_DELAY) &&
                                      (32'(req_task_index) == 32'(i)) &&
                                      (32'(i) < 32'(count_ff));
      assign cell_ctrl[i].tick_en   = accept && (req_op_code == OP_TICK);

      pts_cell #(
         .IDX_W      (IDX_W),
         .SLOT_INDEX (i)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (cell_ctrl[i]),
         .new_priority    (req_task_priority),
         .new_delay       (req_delay_count),
         .best_found_prev (chain_found[i]),
         .best_prio_prev  (chain_prio[i]),
         .best_idx_prev   (chain_idx[i]),
         .best_found      (chain_found[i+1]),
         .best_prio       (chain_prio[i+1]),
         .best_idx        (chain_idx[i+1])
      );
   end

   // Controller: next state and scheduler status
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      tick_in       = tick_ff;
      cur_idx_in    = cur_idx_ff;
      cur_vld_in    = cur_vld_ff;
      nxt_idx_in    = nxt_idx_ff;
      nxt_vld_in    = nxt_vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_create_in = 1'b0;
      rsp_switch_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_op_code;
               scan_in = '0;
               case (req_op_code)
                  OP_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     state_in = ST_SCAN;
                  end
                  OP_LAUNCH: begin
                     state_in = ST_SCAN;
                  end
                  OP_CREATE: begin
                     rsp_valid_in = 1'b1;
                     if (!table_full) begin
                        count_in      = count_ff + CNT_W'(1);
                        rsp_create_in = 1'b1;
                     end
                  end
                  OP_SWITCH_DONE: begin
                     rsp_valid_in = 1'b1;
                     if (nxt_vld_ff) begin
                        cur_idx_in = nxt_idx_ff;
                        cur_vld_in = 1'b1;
                        nxt_vld_in = 1'b0;
                     end
                  end
                  default: begin
                     // delay updates the cell only; unused codes do nothing
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + CNT_W'(1);
            // chain output is settled once every cell has seen the new state
            if (scan_ff == CNT_W'(TASK_SLOTS)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (op_ff == OP_TICK) begin
                  if (chain_found[TASK_SLOTS] &&
                      (!cur_vld_ff || (chain_idx[TASK_SLOTS] != cur_idx_ff))) begin
                     nxt_idx_in    = chain_idx[TASK_SLOTS];
                     nxt_vld_in    = 1'b1;
                     rsp_switch_in = 1'b1;
                  end
               end else begin
                  cur_idx_in = chain_found[TASK_SLOTS] ? chain_idx[TASK_SLOTS] : '0;
                  cur_vld_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_TICK;
         scan_ff       <= '0;
         count_ff      <= '0;
         tick_ff       <= '0;
         cur_idx_ff    <= '0;
         cur_vld_ff    <= 1'b0;
         nxt_idx_ff    <= '0;
         nxt_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_create_ff <= 1'b0;
         rsp_switch_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         scan_ff       <= scan_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
         cur_idx_ff    <= cur_idx_in;
         cur_vld_ff    <= cur_vld_in;
         nxt_idx_ff    <= nxt_idx_in;
         nxt_vld_ff    <= nxt_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_create_ff <= rsp_create_in;
         rsp_switch_ff <= rsp_switch_in;
      end
   end

   // Response beat: status registers hold post-op values while rsp_valid is up
   assign pend_ext  = {3'b000, nxt_idx_ff};
   assign run_ext   = {3'b000, cur_idx_ff};
   assign count_ext = {4'b0000, count_ff};

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_create_ok      = rsp_create_ff;
   assign rsp_switch_request = rsp_switch_ff;
   assign rsp_pending_task   = nxt_vld_ff ? pend_ext[2:0] : 3'b000;
   assign rsp_pending_valid  = nxt_vld_ff;
   assign rsp_running_task   = cur_vld_ff ? run_ext[2:0] : 3'b000;
   assign rsp_running_valid  = cur_vld_ff;
   assign rsp_tick_total     = tick_ff;
   assign rsp_tasks_in_use   = count_ext[3:0];

endmodule
